// File: rtl/csfw_pkg.sv
// Shared constants, codes, command and status types for the semaphore block.
`timescale 1ns / 1ps

package csfw_pkg;

    localparam int MAX_WAITERS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int ID_BITS     = 8;
    localparam int IDX_BITS    = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int LEN_BITS    = $clog2(MAX_WAITERS + 1);
    localparam int STATUS_BITS = 4;
    localparam int REQ_BITS    = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [REQ_BITS-1:0] REQ_POST    = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_WAIT    = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_TRYWAIT = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_TIMEOUT = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_ACQUIRED    = 4'd0;
    localparam logic [STATUS_BITS-1:0] ST_QUEUED      = 4'd1;
    localparam logic [STATUS_BITS-1:0] ST_WOULD_BLOCK = 4'd2;
    localparam logic [STATUS_BITS-1:0] ST_TIMED_OUT   = 4'd3;
    localparam logic [STATUS_BITS-1:0] ST_WOKE        = 4'd4;
    localparam logic [STATUS_BITS-1:0] ST_RAISED      = 4'd5;
    localparam logic [STATUS_BITS-1:0] ST_REMOVED     = 4'd6;
    localparam logic [STATUS_BITS-1:0] ST_FULL        = 4'd7;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN     = 4'd8;

    typedef struct packed {
        logic load_req;
        logic simple_op;
        logic pop_rd;
        logic pop_done;
        logic scan_start;
        logic scan_next;
        logic unknown;
        logic shift_rd;
        logic shift_wr;
        logic remove_done;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [REQ_BITS-1:0] req;
        logic                len_zero;
        logic                match;
        logic                scan_last;
        logic                shift_more;
        logic                out_free;
    } stat_t;

    function automatic logic [IDX_BITS-1:0] wrap_idx(input logic [IDX_BITS-1:0] base,
                                                     input logic [LEN_BITS-1:0] off);
        logic [LEN_BITS:0] s;
        s = (LEN_BITS+1)'(base) + (LEN_BITS+1)'(off);
        if (s >= (LEN_BITS+1)'(MAX_WAITERS)) begin
            s = s - (LEN_BITS+1)'(MAX_WAITERS);
        end
        return s[IDX_BITS-1:0];
    endfunction

endpackage

// File: rtl/counting_semaphore_fifo_waiters.sv
// Top level: counting semaphore with a first-in first-out queue of waiters.
//
// Requests arrive as beats on the s_axis channel (kind in tuser, waiter id
// and deadline flag in tdata); every request yields exactly one result beat
// on the m_axis channel (status in tuser, waiter, count, queue length and
// saturation flag in tdata). The initial count is written through
// cfg_we/cfg_wdata while the block is idle, a rule for the user that the
// block itself does not enforce; it loads the count when no waiter is
// queued and is dropped otherwise. One request is worked on at a time.
// Post with no waiters, wait and trywait pass through the execute and
// finish steps; a post that wakes a waiter also reads and pops the queue
// head. A timeout event walks the queue memory: a read and a compare step
// per entry searched, then a check, a read and a write step per entry
// moved up behind the removed one. The result beat is offered in the same
// cycle in which the next request beat can first be taken. The result sits
// in an output register, so a new beat is taken while it waits; a stalled
// receiver holds the next request in its final step. Synchronous reset
// clears the count, empties the queue and drops the result.
`timescale 1ns / 1ps

module counting_semaphore_fifo_waiters (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [csfw_pkg::COUNT_BITS-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // waiter_id, deadline_passed
    input  logic [1:0]                          s_axis_tuser,  // req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // affected_waiter, count_now, waiters_now, count_saturated
    output logic [31:0]                         m_axis_tdata,
    output logic [3:0]                          m_axis_tuser   // status
);

    csfw_pkg::cmd_t                     cmd;
    csfw_pkg::stat_t                    st;
    logic [csfw_pkg::STATUS_BITS-1:0]   out_status;
    logic [csfw_pkg::ID_BITS-1:0]       out_affected;
    logic [csfw_pkg::COUNT_BITS-1:0]    out_count;
    logic [csfw_pkg::LEN_BITS-1:0]      out_waiters;
    logic                               out_sat;

    csfw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    csfw_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_req       (s_axis_tuser),
        .in_id        (s_axis_tdata[7:0]),
        .in_passed    (s_axis_tdata[8]),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (out_status),
        .out_affected (out_affected),
        .out_count    (out_count),
        .out_waiters  (out_waiters),
        .out_sat      (out_sat)
    );

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {2'b00, out_sat, out_waiters, out_count, out_affected};

endmodule

// File: rtl/csfw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module csfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/csfw_ctrl.sv
// Controller state machine sequencing each request through the datapath.
`timescale 1ns / 1ps

module csfw_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  csfw_pkg::stat_t  st,
    output csfw_pkg::cmd_t   cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_EXEC      = 4'd1;
    localparam logic [3:0] S_POP_RD    = 4'd2;
    localparam logic [3:0] S_POP_WB    = 4'd3;
    localparam logic [3:0] S_SCAN_RD   = 4'd4;
    localparam logic [3:0] S_SCAN_CMP  = 4'd5;
    localparam logic [3:0] S_SHIFT_CHK = 4'd6;
    localparam logic [3:0] S_SHIFT_RD  = 4'd7;
    localparam logic [3:0] S_SHIFT_WR  = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (st.req == csfw_pkg::REQ_POST && !st.len_zero) begin
                    state_next = S_POP_RD;
                end else if (st.req == csfw_pkg::REQ_TIMEOUT) begin
                    if (st.len_zero) begin
                        cmd.unknown = 1'b1;
                        state_next  = S_FINISH;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN_RD;
                    end
                end else begin
                    cmd.simple_op = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_WB;
            end
            S_POP_WB: begin
                cmd.pop_done = 1'b1;
                state_next   = S_FINISH;
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (st.match) begin
                    state_next = S_SHIFT_CHK;
                end else if (st.scan_last) begin
                    cmd.unknown = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SHIFT_CHK: begin
                if (st.shift_more) begin
                    state_next = S_SHIFT_RD;
                end else begin
                    cmd.remove_done = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_SHIFT_RD: begin
                cmd.shift_rd = 1'b1;
                state_next   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_FINISH: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/csfw_dp.sv
// Datapath: count, circular wait queue, search and compaction, result register.
`timescale 1ns / 1ps

module csfw_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [csfw_pkg::COUNT_BITS-1:0]        cfg_wdata,
    input  logic [csfw_pkg::REQ_BITS-1:0]          in_req,
    input  logic [csfw_pkg::ID_BITS-1:0]           in_id,
    input  logic                                   in_passed,
    input  csfw_pkg::cmd_t                         cmd,
    output csfw_pkg::stat_t                        st,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [csfw_pkg::STATUS_BITS-1:0]       out_status,
    output logic [csfw_pkg::ID_BITS-1:0]           out_affected,
    output logic [csfw_pkg::COUNT_BITS-1:0]        out_count,
    output logic [csfw_pkg::LEN_BITS-1:0]          out_waiters,
    output logic                                   out_sat
);

    logic [csfw_pkg::COUNT_BITS-1:0]  count_reg;
    logic [csfw_pkg::IDX_BITS-1:0]    head_reg;
    logic [csfw_pkg::LEN_BITS-1:0]    len_reg;
    logic [csfw_pkg::LEN_BITS-1:0]    pos_reg;
    logic [csfw_pkg::REQ_BITS-1:0]    req_reg;
    logic [csfw_pkg::ID_BITS-1:0]     id_reg;
    logic                             passed_reg;
    logic [csfw_pkg::STATUS_BITS-1:0] res_status_reg;
    logic [csfw_pkg::ID_BITS-1:0]     res_affected_reg;
    logic                             res_sat_reg;
    logic                             out_valid_reg;
    logic [csfw_pkg::STATUS_BITS-1:0] out_status_reg;
    logic [csfw_pkg::ID_BITS-1:0]     out_affected_reg;
    logic [csfw_pkg::COUNT_BITS-1:0]  out_count_reg;
    logic [csfw_pkg::LEN_BITS-1:0]    out_waiters_reg;
    logic                             out_sat_reg;

    logic                             ram_we;
    logic [csfw_pkg::IDX_BITS-1:0]    ram_waddr;
    logic [csfw_pkg::ID_BITS-1:0]     ram_wdata;
    logic [csfw_pkg::IDX_BITS-1:0]    ram_raddr;
    logic [csfw_pkg::ID_BITS-1:0]     ram_rdata;
    logic [csfw_pkg::LEN_BITS:0]      pos_inc;
    logic                             wait_enq;

    csfw_ram #(
        .WIDTH(csfw_pkg::ID_BITS),
        .DEPTH(csfw_pkg::MAX_WAITERS)
    ) u_queue (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign pos_inc  = (csfw_pkg::LEN_BITS+1)'(pos_reg) + (csfw_pkg::LEN_BITS+1)'(1);
    assign wait_enq = cmd.simple_op && req_reg == csfw_pkg::REQ_WAIT
                      && count_reg == '0 && !passed_reg
                      && len_reg != csfw_pkg::LEN_BITS'(csfw_pkg::MAX_WAITERS);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = csfw_pkg::wrap_idx(head_reg, len_reg);
        ram_wdata = id_reg;
        ram_raddr = csfw_pkg::wrap_idx(head_reg, pos_reg);
        if (wait_enq) begin
            ram_we = 1'b1;
        end
        if (cmd.pop_rd) begin
            ram_raddr = head_reg;
        end
        if (cmd.shift_rd) begin
            ram_raddr = csfw_pkg::wrap_idx(head_reg, pos_inc[csfw_pkg::LEN_BITS-1:0]);
        end
        if (cmd.shift_wr) begin
            ram_we    = 1'b1;
            ram_waddr = csfw_pkg::wrap_idx(head_reg, pos_reg);
            ram_wdata = ram_rdata;
        end
    end

    assign st.req        = req_reg;
    assign st.len_zero   = (len_reg == '0);
    assign st.match      = (ram_rdata == id_reg);
    assign st.scan_last  = (pos_inc == (csfw_pkg::LEN_BITS+1)'(len_reg));
    assign st.shift_more = (pos_inc < (csfw_pkg::LEN_BITS+1)'(len_reg));
    assign st.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg     <= in_req;
            id_reg      <= in_id;
            passed_reg  <= in_passed;
            res_sat_reg <= 1'b0;
        end
        if (cmd.scan_start) begin
            pos_reg <= '0;
        end
        if (cmd.scan_next || cmd.shift_wr) begin
            pos_reg <= pos_inc[csfw_pkg::LEN_BITS-1:0];
        end
        if (cmd.pop_done) begin
            res_status_reg   <= csfw_pkg::ST_WOKE;
            res_affected_reg <= ram_rdata;
        end
        if (cmd.unknown) begin
            res_status_reg   <= csfw_pkg::ST_UNKNOWN;
            res_affected_reg <= id_reg;
        end
        if (cmd.remove_done) begin
            res_status_reg   <= csfw_pkg::ST_REMOVED;
            res_affected_reg <= id_reg;
        end
        if (cmd.simple_op) begin
            res_affected_reg <= id_reg;
            case (req_reg)
                csfw_pkg::REQ_POST: begin
                    res_status_reg <= csfw_pkg::ST_RAISED;
                    res_sat_reg    <= (count_reg == csfw_pkg::COUNT_MAX);
                end
                csfw_pkg::REQ_WAIT: begin
                    if (count_reg != '0) begin
                        res_status_reg <= csfw_pkg::ST_ACQUIRED;
                    end else if (passed_reg) begin
                        res_status_reg <= csfw_pkg::ST_TIMED_OUT;
                    end else if (!wait_enq) begin
                        res_status_reg <= csfw_pkg::ST_FULL;
                    end else begin
                        res_status_reg <= csfw_pkg::ST_QUEUED;
                    end
                end
                csfw_pkg::REQ_TRYWAIT: begin
                    if (count_reg != '0) begin
                        res_status_reg <= csfw_pkg::ST_ACQUIRED;
                    end else begin
                        res_status_reg <= csfw_pkg::ST_WOULD_BLOCK;
                    end
                end
                default: begin
                    res_status_reg <= csfw_pkg::ST_UNKNOWN;
                end
            endcase
        end
        if (cmd.finish) begin
            out_status_reg   <= res_status_reg;
            out_affected_reg <= res_affected_reg;
            out_count_reg    <= count_reg;
            out_waiters_reg  <= len_reg;
            out_sat_reg      <= res_sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            head_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (len_reg == '0) begin
                    count_reg <= cfg_wdata;
                end
            end
            if (cmd.simple_op) begin
                if (req_reg == csfw_pkg::REQ_POST) begin
                    if (count_reg != csfw_pkg::COUNT_MAX) begin
                        count_reg <= count_reg + csfw_pkg::COUNT_BITS'(1);
                    end
                end else if (count_reg != '0) begin
                    count_reg <= count_reg - csfw_pkg::COUNT_BITS'(1);
                end
            end
            if (wait_enq) begin
                len_reg <= len_reg + csfw_pkg::LEN_BITS'(1);
            end
            if (cmd.pop_done) begin
                head_reg <= csfw_pkg::wrap_idx(head_reg, csfw_pkg::LEN_BITS'(1));
                len_reg  <= len_reg - csfw_pkg::LEN_BITS'(1);
            end
            if (cmd.remove_done) begin
                len_reg <= len_reg - csfw_pkg::LEN_BITS'(1);
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_affected = out_affected_reg;
    assign out_count    = out_count_reg;
    assign out_waiters  = out_waiters_reg;
    assign out_sat      = out_sat_reg;

endmodule
